FILE: src/tolp_pkg.sv
// Shared widths, constants and types of the third-order lowpass.
package tolp_pkg;

  localparam int SampleBits = 24;
  localparam int CoefBits   = 32;
  localparam int StateBits  = 32;
  localparam int CoefFrac   = CoefBits - 3;
  localparam int StateFrac  = StateBits - 1;
  localparam int SampleFrac = SampleBits - 1;
  localparam int CutBits    = 24;
  localparam int RateBits   = 18;

  localparam int OpBits   = 33;
  localparam int ProdBits = 2 * OpBits;
  localparam int AccBits  = 80;
  localparam int DvdBits  = 96;
  localparam int DenBits  = 64;
  localparam int DivSteps = DvdBits;
  localparam int CntBits  = $clog2(DivSteps);

  localparam logic [OpBits-1:0] TwoPiQ29 = 33'd3373259426;
  localparam logic [OpBits-1:0] WcRound  = 33'd26214400;
  localparam logic [DenBits-1:0] WcDen   = 64'd52428800;
  localparam logic [OpBits-1:0] PoleK    = 33'd6203;
  localparam logic [OpBits-1:0] DampK    = 33'd6904;
  localparam logic [OpBits-1:0] NatK     = 33'd9308;
  localparam logic [OpBits-1:0] DecRound = 33'd5000;
  localparam logic [DenBits-1:0] DecDen  = 64'd10000;

  typedef struct packed {
    logic vld;
    logic clr;
    logic sub;
    logic hi;
  } mac_ctl_t;

endpackage

FILE: src/third_order_optimum_l_lowpass_unit.sv
// Third-order optimum-L lowpass: one-pole stage and biquad on a shared MAC and divider.
// One sample runs from the accepted beat to the output beat through eight
// multiply-accumulates on the two-stage shared MAC plus two pipeline drains.
// The first sample after reset or after any register write first recomputes the five
// coefficients, with nine passes through the shared divider. A new input beat is taken
// while the previous output beat waits.
module third_order_optimum_l_lowpass_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [23:0] sample_out
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [23:0] cfg_wdata_i
);

  localparam logic RegCutoff = 1'b0;
  localparam logic RegRate   = 1'b1;

  localparam int IdxPb = 0;
  localparam int IdxPa = 1;
  localparam int IdxB0 = 2;
  localparam int IdxA1 = 3;
  localparam int IdxA2 = 4;

  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_CLAMP   = 6'd1;
  localparam logic [5:0] S_WC_MUL  = 6'd2;
  localparam logic [5:0] S_WC_RND  = 6'd3;
  localparam logic [5:0] S_WC_DIV  = 6'd4;
  localparam logic [5:0] S_WC_GET  = 6'd5;
  localparam logic [5:0] S_P_MUL   = 6'd6;
  localparam logic [5:0] S_P_RND   = 6'd7;
  localparam logic [5:0] S_P_DIV   = 6'd8;
  localparam logic [5:0] S_P_GET   = 6'd9;
  localparam logic [5:0] S_D_MUL   = 6'd10;
  localparam logic [5:0] S_D_RND   = 6'd11;
  localparam logic [5:0] S_D_DIV   = 6'd12;
  localparam logic [5:0] S_D_GET   = 6'd13;
  localparam logic [5:0] S_W2_MUL  = 6'd14;
  localparam logic [5:0] S_W2_GET  = 6'd15;
  localparam logic [5:0] S_N_LO    = 6'd16;
  localparam logic [5:0] S_N_HI    = 6'd17;
  localparam logic [5:0] S_N_RND   = 6'd18;
  localparam logic [5:0] S_N_DIV   = 6'd19;
  localparam logic [5:0] S_N_GET   = 6'd20;
  localparam logic [5:0] S_KK_MUL  = 6'd21;
  localparam logic [5:0] S_KK_GET  = 6'd22;
  localparam logic [5:0] S_AK_MUL  = 6'd23;
  localparam logic [5:0] S_AK_GET  = 6'd24;
  localparam logic [5:0] S_PB_DIV  = 6'd25;
  localparam logic [5:0] S_PB_GET  = 6'd26;
  localparam logic [5:0] S_PA_DIV  = 6'd27;
  localparam logic [5:0] S_PA_GET  = 6'd28;
  localparam logic [5:0] S_DEN     = 6'd29;
  localparam logic [5:0] S_B0_DIV  = 6'd30;
  localparam logic [5:0] S_B0_GET  = 6'd31;
  localparam logic [5:0] S_A1_DIV  = 6'd32;
  localparam logic [5:0] S_A1_GET  = 6'd33;
  localparam logic [5:0] S_A2_DIV  = 6'd34;
  localparam logic [5:0] S_A2_GET  = 6'd35;
  localparam logic [5:0] S_F_P0    = 6'd36;
  localparam logic [5:0] S_F_P1    = 6'd37;
  localparam logic [5:0] S_F_P2    = 6'd38;
  localparam logic [5:0] S_F_PO    = 6'd39;
  localparam logic [5:0] S_F_B0    = 6'd40;
  localparam logic [5:0] S_F_B1    = 6'd41;
  localparam logic [5:0] S_F_B2    = 6'd42;
  localparam logic [5:0] S_F_B3    = 6'd43;
  localparam logic [5:0] S_F_B4    = 6'd44;
  localparam logic [5:0] S_F_BO    = 6'd45;

  localparam int OB = tolp_pkg::OpBits;
  localparam int AB = tolp_pkg::AccBits;

  logic [5:0]  pc_q, pc_d;
  logic        cv_q, ov_q;
  logic [23:0] cut_q;
  logic [17:0] rate_q;

  logic signed [23:0] x_q, pin_q;
  logic signed [31:0] pout_q, bi0_q, bi1_q, bo0_q, bo1_q;
  logic signed [31:0] coef_q [5];
  logic [23:0] ctmp_q, y_q, lim, cclamp;
  logic [31:0] wc_q, p_q, a1s_q;
  logic [63:0] w2_q, a0s_q, kk_q, a1k_q, bden_q, k_w, kp_w;
  logic        neg_q;

  tolp_pkg::mac_ctl_t mac_ctl;
  logic signed [OB-1:0] mac_a, mac_b;
  logic signed [AB-1:0] acc;
  logic        mac_busy, div_busy, div_start;
  logic [tolp_pkg::DvdBits-1:0] div_dvd, acc_dvd, frac_dvd;
  logic [tolp_pkg::DenBits-1:0] div_den, quot;

  logic signed [65:0] num_s;
  logic [65:0]        mag;
  logic [32:0]        rq;
  logic signed [31:0] frac_coef, po_sat, bo_sat;
  logic signed [AB-1:0] acc_rnd;
  logic signed [32:0] bo_rnd;
  logic [23:0]        y_sat;
  logic               accept, fire_out;

  function automatic tolp_pkg::mac_ctl_t op(input logic clr, input logic sub, input logic hi);
    tolp_pkg::mac_ctl_t c;
    c.vld = 1'b1;
    c.clr = clr;
    c.sub = sub;
    c.hi  = hi;
    return c;
  endfunction

  function automatic logic signed [OB-1:0] sx(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AB-1:0] v);
    if (v > $signed(80'h7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -$signed(80'h8000_0000)) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  tolp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  tolp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign lim    = 24'({6'd0, rate_q} * 24'd49);
  assign cclamp = (cut_q > lim) ? ((lim == '0) ? 24'd1 : lim)
                                : ((cut_q == '0) ? 24'd1 : cut_q);
  assign k_w    = {35'd0, rate_q, 11'd0};
  assign kp_w   = k_w + {32'd0, p_q};

  always_comb begin
    unique case (pc_q)
      S_PB_DIV: num_s = $signed({34'd0, p_q});
      S_PA_DIV: num_s = $signed({34'd0, p_q}) - $signed({2'd0, k_w});
      S_B0_DIV: num_s = $signed({2'd0, a0s_q});
      S_A1_DIV: num_s = $signed({1'b0, a0s_q, 1'b0}) - $signed({1'b0, kk_q, 1'b0});
      S_A2_DIV: num_s = $signed({2'd0, kk_q}) + $signed({2'd0, a0s_q})
                        - $signed({2'd0, a1k_q});
      default:  num_s = '0;
    endcase
  end

  assign mag      = num_s[65] ? 66'(-num_s) : num_s;
  assign frac_dvd = {2'd0, mag[63:0], 30'd0};
  assign acc_dvd  = {16'd0, acc};
  assign rq       = {1'b0, quot[31:0]} + 33'd1;
  assign frac_coef = neg_q ? -$signed(rq[32:1]) : $signed(rq[32:1]);

  assign acc_rnd = (acc + $signed(80'h1000_0000)) >>> tolp_pkg::CoefFrac;
  assign po_sat  = sat32(acc_rnd);
  assign bo_sat  = sat32(acc_rnd);
  assign bo_rnd  = ($signed({bo_sat[31], bo_sat}) + 33'sd128) >>> 8;
  assign y_sat   = (bo_rnd > 33'sh7F_FFFF) ? 24'h7F_FFFF :
                   (bo_rnd < -33'sh80_0000) ? 24'h80_0000 : bo_rnd[23:0];

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign fire_out = (pc_q == S_F_BO) && !mac_busy && (!ov_q || m_axis_tready);

  always_comb begin
    pc_d      = pc_q;
    mac_ctl   = '0;
    mac_a     = '0;
    mac_b     = '0;
    div_start = 1'b0;
    div_dvd   = acc_dvd;
    div_den   = tolp_pkg::DecDen;
    unique case (pc_q)
      S_IDLE: if (s_axis_tvalid) pc_d = cv_q ? S_F_P0 : S_CLAMP;
      S_CLAMP: pc_d = S_WC_MUL;
      S_WC_MUL: begin
        mac_ctl = op(1'b1, 1'b0, 1'b0);
        mac_a   = {9'd0, ctmp_q};
        mac_b   = tolp_pkg::TwoPiQ29;
        pc_d    = S_WC_RND;
      end
      S_WC_RND: begin
        mac_ctl = op(1'b0, 1'b0, 1'b0);
        mac_a   = tolp_pkg::WcRound;
        mac_b   = 33'sd1;
        pc_d    = S_WC_DIV;
      end
      S_WC_DIV: if (!mac_busy) begin
        div_start = 1'b1;
        div_den   = tolp_pkg::WcDen;
        pc_d      = S_WC_GET;
      end
      S_WC_GET: if (!div_busy) pc_d = S_P_MUL;
      S_P_MUL: begin
        mac_ctl = op(1'b1, 1'b0, 1'b0);
        mac_a   = {1'b0, wc_q};
        mac_b   = tolp_pkg::PoleK;
        pc_d    = S_P_RND;
      end
      S_P_RND: begin
        mac_ctl = op(1'b0, 1'b0, 1'b0);
        mac_a   = tolp_pkg::DecRound;
        mac_b   = 33'sd1;
        pc_d    = S_P_DIV;
      end
      S_P_DIV: if (!mac_busy) begin
        div_start = 1'b1;
        pc_d      = S_P_GET;
      end
      S_P_GET: if (!div_busy) pc_d = S_D_MUL;
      S_D_MUL: begin
        mac_ctl = op(1'b1, 1'b0, 1'b0);
        mac_a   = {1'b0, wc_q};
        mac_b   = tolp_pkg::DampK;
        pc_d    = S_D_RND;
      end
      S_D_RND: begin
        mac_ctl = op(1'b0, 1'b0, 1'b0);
        mac_a   = tolp_pkg::DecRound;
        mac_b   = 33'sd1;
        pc_d    = S_D_DIV;
      end
      S_D_DIV: if (!mac_busy) begin
        div_start = 1'b1;
        pc_d      = S_D_GET;
      end
      S_D_GET: if (!div_busy) pc_d = S_W2_MUL;
      S_W2_MUL: begin
        mac_ctl = op(1'b1, 1'b0, 1'b0);
        mac_a   = {1'b0, wc_q};
        mac_b   = {1'b0, wc_q};
        pc_d    = S_W2_GET;
      end
      S_W2_GET: if (!mac_busy) pc_d = S_N_LO;
      S_N_LO: begin
        mac_ctl = op(1'b1, 1'b0, 1'b0);
        mac_a   = {1'b0, w2_q[31:0]};
        mac_b   = tolp_pkg::NatK;
        pc_d    = S_N_HI;
      end
      S_N_HI: begin
        mac_ctl = op(1'b0, 1'b0, 1'b1);
        mac_a   = {1'b0, w2_q[63:32]};
        mac_b   = tolp_pkg::NatK;
        pc_d    = S_N_RND;
      end
      S_N_RND: begin
        mac_ctl = op(1'b0, 1'b0, 1'b0);
        mac_a   = tolp_pkg::DecRound;
        mac_b   = 33'sd1;
        pc_d    = S_N_DIV;
      end
      S_N_DIV: if (!mac_busy) begin
        div_start = 1'b1;
        pc_d      = S_N_GET;
      end
      S_N_GET: if (!div_busy) pc_d = S_KK_MUL;
      S_KK_MUL: begin
        mac_ctl = op(1'b1, 1'b0, 1'b0);
        mac_a   = {1'b0, k_w[31:0]};
        mac_b   = {1'b0, k_w[31:0]};
        pc_d    = S_KK_GET;
      end
      S_KK_GET: if (!mac_busy) pc_d = S_AK_MUL;
      S_AK_MUL: begin
        mac_ctl = op(1'b1, 1'b0, 1'b0);
        mac_a   = {1'b0, a1s_q};
        mac_b   = {1'b0, k_w[31:0]};
        pc_d    = S_AK_GET;
      end
      S_AK_GET: if (!mac_busy) pc_d = S_PB_DIV;
      S_PB_DIV, S_PA_DIV: begin
        div_start = 1'b1;
        div_dvd   = frac_dvd;
        div_den   = kp_w;
        pc_d      = pc_q + 6'd1;
      end
      S_B0_DIV, S_A1_DIV, S_A2_DIV: begin
        div_start = 1'b1;
        div_dvd   = frac_dvd;
        div_den   = bden_q;
        pc_d      = pc_q + 6'd1;
      end
      S_PB_GET, S_PA_GET, S_B0_GET, S_A1_GET: if (!div_busy) pc_d = pc_q + 6'd1;
      S_DEN: pc_d = S_B0_DIV;
      S_A2_GET: if (!div_busy) pc_d = S_F_P0;
      S_F_P0: begin
        mac_ctl = op(1'b1, 1'b0, 1'b0);
        mac_a   = sx(coef_q[IdxPb]);
        mac_b   = {x_q[23], x_q, 8'd0};
        pc_d    = S_F_P1;
      end
      S_F_P1: begin
        mac_ctl = op(1'b0, 1'b0, 1'b0);
        mac_a   = sx(coef_q[IdxPb]);
        mac_b   = {pin_q[23], pin_q, 8'd0};
        pc_d    = S_F_P2;
      end
      S_F_P2: begin
        mac_ctl = op(1'b0, 1'b1, 1'b0);
        mac_a   = sx(coef_q[IdxPa]);
        mac_b   = sx(pout_q);
        pc_d    = S_F_PO;
      end
      S_F_PO: if (!mac_busy) pc_d = S_F_B0;
      S_F_B0: begin
        mac_ctl = op(1'b1, 1'b0, 1'b0);
        mac_a   = sx(coef_q[IdxB0]);
        mac_b   = sx(pout_q);
        pc_d    = S_F_B1;
      end
      S_F_B1: begin
        mac_ctl = op(1'b0, 1'b0, 1'b0);
        mac_a   = {coef_q[IdxB0], 1'b0};
        mac_b   = sx(bi0_q);
        pc_d    = S_F_B2;
      end
      S_F_B2: begin
        mac_ctl = op(1'b0, 1'b0, 1'b0);
        mac_a   = sx(coef_q[IdxB0]);
        mac_b   = sx(bi1_q);
        pc_d    = S_F_B3;
      end
      S_F_B3: begin
        mac_ctl = op(1'b0, 1'b1, 1'b0);
        mac_a   = sx(coef_q[IdxA1]);
        mac_b   = sx(bo0_q);
        pc_d    = S_F_B4;
      end
      S_F_B4: begin
        mac_ctl = op(1'b0, 1'b1, 1'b0);
        mac_a   = sx(coef_q[IdxA2]);
        mac_b   = sx(bo1_q);
        pc_d    = S_F_BO;
      end
      S_F_BO: if (fire_out) pc_d = S_IDLE;
      default: pc_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= S_IDLE;
      cv_q   <= 1'b0;
      ov_q   <= 1'b0;
      cut_q  <= 24'd100000;
      rate_q <= 18'd48000;
      pin_q  <= '0;
      pout_q <= '0;
      bi0_q  <= '0;
      bi1_q  <= '0;
      bo0_q  <= '0;
      bo1_q  <= '0;
    end else begin
      pc_q <= pc_d;
      if (cfg_we_i) begin
        cv_q <= 1'b0;
        unique case (cfg_addr_i)
          RegCutoff: cut_q  <= cfg_wdata_i;
          RegRate:   rate_q <= cfg_wdata_i[17:0];
          default:   cut_q  <= cut_q;
        endcase
      end else if (pc_q == S_A2_GET && !div_busy) begin
        cv_q <= 1'b1;
      end
      if (pc_q == S_F_PO && !mac_busy) begin
        pin_q  <= x_q;
        pout_q <= po_sat;
      end
      if (fire_out) begin
        bi1_q <= bi0_q;
        bi0_q <= pout_q;
        bo1_q <= bo0_q;
        bo0_q <= bo_sat;
        ov_q  <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) x_q <= s_axis_tdata;
    if (fire_out) y_q <= y_sat;
    if (div_start) neg_q <= num_s[65];
    unique case (pc_q)
      S_CLAMP:  ctmp_q <= cclamp;
      S_WC_GET: if (!div_busy) wc_q <= quot[31:0];
      S_P_GET:  if (!div_busy) p_q <= quot[31:0];
      S_D_GET:  if (!div_busy) a1s_q <= quot[31:0];
      S_W2_GET: if (!mac_busy) w2_q <= acc[63:0];
      S_N_GET:  if (!div_busy) a0s_q <= quot;
      S_KK_GET: if (!mac_busy) kk_q <= acc[63:0];
      S_AK_GET: if (!mac_busy) a1k_q <= acc[63:0];
      S_DEN:    bden_q <= kk_q + a1k_q + a0s_q;
      S_PB_GET: if (!div_busy) coef_q[IdxPb] <= frac_coef;
      S_PA_GET: if (!div_busy) coef_q[IdxPa] <= frac_coef;
      S_B0_GET: if (!div_busy) coef_q[IdxB0] <= frac_coef;
      S_A1_GET: if (!div_busy) coef_q[IdxA1] <= frac_coef;
      S_A2_GET: if (!div_busy) coef_q[IdxA2] <= frac_coef;
      default:  ctmp_q <= ctmp_q;
    endcase
  end

  assign s_axis_tready = (pc_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = y_q;

`ifndef SYNTHESIS
  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mac_busy && !div_busy)
    else $error("shared units busy while idle");
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_accept_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (pc_q == S_CLAMP) || (pc_q == S_F_P0))
    else $error("bad step after accepted beat");
  a_coef_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == S_F_P0) |-> cv_q)
    else $error("filtering with stale coefficients");
`endif

endmodule

FILE: src/tolp_mac.sv
// Shared signed multiplier with a registered product and a wide accumulator.
module tolp_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tolp_pkg::mac_ctl_t                  ctl_i,
  input  logic signed [tolp_pkg::OpBits-1:0]  a_i,
  input  logic signed [tolp_pkg::OpBits-1:0]  b_i,
  output logic signed [tolp_pkg::AccBits-1:0] acc_o,
  output logic                                busy_o
);

  tolp_pkg::mac_ctl_t                     ctl_q;
  logic signed [tolp_pkg::ProdBits-1:0]   prod_q;
  logic signed [tolp_pkg::AccBits-1:0]    acc_q, prod_ext, term, base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctl_q.vld) begin
      acc_q <= ctl_q.sub ? base - term : base + term;
    end
  end

  assign prod_ext = {{(tolp_pkg::AccBits - tolp_pkg::ProdBits){prod_q[tolp_pkg::ProdBits-1]}},
                     prod_q};
  assign term     = ctl_q.hi ? {prod_ext[tolp_pkg::AccBits-33:0], 32'd0} : prod_ext;
  assign base     = ctl_q.clr ? '0 : acc_q;
  assign acc_o    = acc_q;
  assign busy_o   = ctl_q.vld;

endmodule

FILE: src/tolp_div.sv
// Shared restoring divider, one quotient bit per cycle.
module tolp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tolp_pkg::DvdBits-1:0]  dividend_i,
  input  logic [tolp_pkg::DenBits-1:0]  divisor_i,
  output logic                          busy_o,
  output logic [tolp_pkg::DenBits-1:0]  quot_o
);

  logic                          busy_q;
  logic [tolp_pkg::CntBits-1:0]  cnt_q;
  logic [tolp_pkg::DvdBits-1:0]  dvd_q;
  logic [tolp_pkg::DenBits-1:0]  den_q, rem_q, quot_q;
  logic [tolp_pkg::DenBits:0]    r2, diff;
  logic                          ge;

  assign r2   = {rem_q, dvd_q[tolp_pkg::DvdBits-1]};
  assign diff = r2 - {1'b0, den_q};
  assign ge   = r2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == tolp_pkg::CntBits'(tolp_pkg::DivSteps - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[tolp_pkg::DvdBits-2:0], 1'b0};
      rem_q  <= ge ? diff[tolp_pkg::DenBits-1:0] : r2[tolp_pkg::DenBits-1:0];
      quot_q <= {quot_q[tolp_pkg::DenBits-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

FILE: tb/third_order_optimum_l_lowpass_unit_tb.sv
// Self-checking testbench of the third-order optimum-L lowpass unit.
module third_order_optimum_l_lowpass_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CfgCutoff = 1'b0;
  localparam logic CfgRate   = 1'b1;
  localparam logic signed [23:0] SampleMax = 24'sh7fffff;
  localparam logic signed [23:0] SampleMin = -24'sh800000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [23:0] sample_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [23:0] sample_out
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = 1'b0;
  logic [23:0] cfg_wdata_i = '0;

  third_order_optimum_l_lowpass_unit u_dut (.*);

  always #4 clk_i = ~clk_i;

  // filter shadow
  logic [tolp_pkg::CutBits-1:0]  cutoff_q;
  logic [tolp_pkg::RateBits-1:0] rate_q;
  longint coef_q [5];
  bit     coef_ok;
  longint pole_x1, pole_y1;
  longint bq_x [2];
  longint bq_y [2];

  logic [23:0] expected_samples [$];
  int  err_cnt = 0;
  bit  src_idle_en = 1'b1;
  bit  sink_stall_en = 1'b1;
  int  sink_wait = 0;

  function automatic longint div_mag(longint unsigned num, longint unsigned den);
    longint unsigned q, rem;
    q = num / den;
    rem = num % den;
    for (int i = 0; i < tolp_pkg::CoefFrac + 1; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 64'd1;
      end
    end
    return longint'((q + 64'd1) >> 1);
  endfunction

  function automatic longint div_sgn(longint num, longint unsigned den);
    if (num < 0) return -div_mag(longint'(-num), den);
    return div_mag(num, den);
  endfunction

  function automatic longint sat(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic void update_coefs();
    longint unsigned r, c, wc, p, a1s, w2, a0s, k, kk, a1k, den;
    r = rate_q;
    c = cutoff_q;
    if (c > 49 * r) c = 49 * r;
    if (c < 1) c = 1;
    wc  = (c * 64'd3373259426 + 64'd26214400) / 64'd52428800;
    p   = (wc * 6203 + 5000) / 10000;
    a1s = (wc * 6904 + 5000) / 10000;
    w2  = wc * wc;
    a0s = (w2 / 10000) * 9308 + ((w2 % 10000) * 9308 + 5000) / 10000;
    k   = r << 11;
    kk  = k * k;
    a1k = a1s * k;
    den = kk + a1k + a0s;
    coef_q[0] = div_mag(p, k + p);
    coef_q[1] = div_sgn(longint'(p) - longint'(k), k + p);
    coef_q[2] = div_mag(a0s, den);
    coef_q[3] = div_sgn(2 * longint'(a0s) - 2 * longint'(kk), den);
    coef_q[4] = div_sgn(longint'(kk + a0s) - longint'(a1k), den);
    coef_ok = 1'b1;
  endfunction

  function automatic logic [23:0] lowpass_predict(logic signed [23:0] x);
    longint xs, acc, po, bo;
    xs = longint'(x);
    if (!coef_ok) update_coefs();
    acc = coef_q[0] * (xs * 256) + coef_q[0] * (pole_x1 * 256) - coef_q[1] * pole_y1;
    po = sat(rnd_shift(acc, tolp_pkg::CoefFrac), tolp_pkg::StateBits);
    pole_x1 = xs;
    pole_y1 = po;
    acc = coef_q[2] * po + (2 * coef_q[2]) * bq_x[0] + coef_q[2] * bq_x[1]
        - coef_q[3] * bq_y[0] - coef_q[4] * bq_y[1];
    bo = sat(rnd_shift(acc, tolp_pkg::CoefFrac), tolp_pkg::StateBits);
    bq_x[1] = bq_x[0];
    bq_x[0] = po;
    bq_y[1] = bq_y[0];
    bq_y[0] = bo;
    return 24'(sat(rnd_shift(bo, tolp_pkg::StateFrac - tolp_pkg::SampleFrac),
                   tolp_pkg::SampleBits));
  endfunction

  task automatic send_sample(logic signed [23:0] x);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_samples.push_back(lowpass_predict(x));
  endtask

  task automatic cfg_write(logic addr, logic [23:0] data);
    s_axis_tvalid <= 1'b0;
    wait (expected_samples.size() == 0);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == CfgCutoff) cutoff_q = data[tolp_pkg::CutBits-1:0];
    else rate_q = data[tolp_pkg::RateBits-1:0];
    coef_ok = 1'b0;
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return SampleMax;
      1: return SampleMin;
      2: return 24'($signed($urandom_range(0, 511)) - 256);
      default: return 24'($urandom);
    endcase
  endfunction

  // sink side: random stall per beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected beat sample_out=%0d", $signed(m_axis_tdata));
          err_cnt++;
        end else if (m_axis_tdata !== expected_samples[0]) begin
          $error("sample_out expected %0d actual %0d",
                 $signed(expected_samples.pop_front()), $signed(m_axis_tdata));
          err_cnt++;
        end else begin
          void'(expected_samples.pop_front());
        end
        sink_wait = sink_stall_en ? $urandom_range(0, 13) : 0;
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic test_reset_defaults();
    send_sample(SampleMax);
    repeat (6) send_sample(24'sd0);
    send_sample(SampleMin);
    send_sample(SampleMin);
    repeat (4) send_sample(SampleMax);
    send_sample(24'sd1);
    send_sample(-24'sd1);
    repeat (3) send_sample(rand_sample());
  endtask

  task automatic test_config_corners();
    logic [23:0] cuts [4];
    logic [23:0] rates [5];
    cuts  = '{24'd0, 24'd1, 24'd9408000, 24'hffffff};
    rates = '{24'd8000, 24'd192000, 24'd0, 24'd100, 24'hffffff};
    foreach (rates[i]) begin
      cfg_write(CfgRate, rates[i]);
      foreach (cuts[j]) begin
        cfg_write(CfgCutoff, cuts[j]);
        send_sample(SampleMax);
        send_sample(SampleMin);
        repeat (8) send_sample(rand_sample());
      end
    end
  endtask

  task automatic test_random_stream();
    int unsigned r;
    for (int blk = 0; blk < 12; blk++) begin
      r = $urandom_range(8000, 192000);
      cfg_write(CfgRate, 24'(r));
      cfg_write(CfgCutoff, 24'($urandom_range(1, 49 * r)));
      src_idle_en   = (blk % 4) != 1;
      sink_stall_en = (blk % 4) != 2;
      repeat (120) send_sample(rand_sample());
    end
    src_idle_en = 1'b1;
    sink_stall_en = 1'b1;
    cfg_write(CfgCutoff, 24'd100000);
    cfg_write(CfgRate, 24'd48000);
    repeat (50) send_sample(rand_sample());
  endtask

  initial begin
    cutoff_q = 24'd100000;
    rate_q   = 18'd48000;
    coef_ok  = 1'b0;
    pole_x1 = 0; pole_y1 = 0;
    bq_x = '{0, 0};
    bq_y = '{0, 0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_config_corners();
    test_random_stream();
    s_axis_tvalid <= 1'b0;
    wait (expected_samples.size() == 0);
    repeat (30) @(posedge clk_i);
    if (err_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
